[hw/rtl/lj_cutoff_pair_energy_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Lennard-Jones pair energy core
// Clocked assertions; LJC_ASSERT adds an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef LJ_CUTOFF_PAIR_ENERGY_CORE_DEFINES_SVH
`define LJ_CUTOFF_PAIR_ENERGY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LJC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LJC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LJC_ASSERT(lbl, clk, rst_n, prop)
`define LJC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[hw/rtl/ljc_pkg.sv]
// ---------------------------------------------------------------------------
// ljc_pkg
// Shared constants, codes and saturating arithmetic for the LJ energy core.
// ---------------------------------------------------------------------------
package ljc_pkg;

    localparam int NTYPES_DEF = 8;
    localparam int Q_W        = 64;
    localparam int CRD_W      = 32;
    localparam int TYPE_W     = 3;
    localparam int S_DATA_W   = 264;   // 262 field bits padded to bytes
    localparam int S_USER_W   = 3;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // request kinds
    localparam logic REQ_COEF = 1'b0;
    localparam logic REQ_PAIR = 1'b1;

    // table selectors
    localparam logic [1:0] SEL_CUT   = 2'd0;
    localparam logic [1:0] SEL_REP   = 2'd1;
    localparam logic [1:0] SEL_ATT   = 2'd2;
    localparam logic [1:0] SEL_SHIFT = 2'd3;

    // product stages of one pair evaluation
    localparam logic [1:0] OP_R4  = 2'd0;   // r2inv * r2inv
    localparam logic [1:0] OP_R6  = 2'd1;   // r4 * r2inv
    localparam logic [1:0] OP_AR6 = 2'd2;   // A * r6inv
    localparam logic [1:0] OP_PHI = 2'd3;   // r6inv * t

    typedef struct packed {
        logic        ovf;
        logic [63:0] val;
    } t_sat_res;

    function automatic t_sat_res sat_add(input logic [63:0] a, input logic [63:0] b);
        t_sat_res   res;
        logic [63:0] r;
        r = a + b;
        res.ovf = (a[63] == b[63]) && (r[63] != a[63]);
        res.val = res.ovf ? (a[63] ? SMIN : SMAX) : r;
        return res;
    endfunction

    function automatic t_sat_res sat_sub(input logic [63:0] a, input logic [63:0] b);
        t_sat_res   res;
        logic [63:0] r;
        r = a - b;
        res.ovf = (a[63] != b[63]) && (r[63] != a[63]);
        res.val = res.ovf ? (a[63] ? SMIN : SMAX) : r;
        return res;
    endfunction

    // Magnitude product back to signed Q32.32, truncated toward zero
    function automatic t_sat_res q_final(input logic [127:0] p, input logic neg);
        t_sat_res   res;
        logic [63:0] m;
        m = p[95:32];
        if (p[127:96] != 32'd0) begin
            res.ovf = 1'b1;
            res.val = neg ? SMIN : SMAX;
        end else if (neg) begin
            res.ovf = (m > SMIN);
            res.val = res.ovf ? SMIN : (64'd0 - m);
        end else begin
            res.ovf = (m > SMAX);
            res.val = res.ovf ? SMAX : m;
        end
        return res;
    endfunction

endpackage

[hw/rtl/lj_cutoff_pair_energy_core.sv]
// ---------------------------------------------------------------------------
// lj_cutoff_pair_energy_core
// Cut-off, shifted Lennard-Jones 12-6 energy sum of one centre atom.
// ---------------------------------------------------------------------------
// Input stream: one transfer per request. tuser[0] = 0 writes one coefficient
// word (tuser[2:1] picks the table) at the type pair; tuser[0] = 1 evaluates
// one centre/neighbour pair, and tlast marks the last neighbour of a centre.
// Output stream: one transfer per run, the saturated Q32.32 total in tdata,
// and in tuser[0] the flag for any saturation or zero distance in that run.
// A coefficient write keeps the block idle, so the next transfer can be taken
// in the cycle after it. A pair inside the cut-off runs four table reads from
// the single coefficient RAM, the squared distance, the bit-serial reciprocal
// and four Q32.32 products on one shared 32x32 multiplier, then saturating
// subtracts and an add. A pair outside the cut-off skips the reciprocal and
// the products; a pair with a type out of range skips all of these steps.
// The total sits in an output register, so a stalled receiver does not stop
// input: the block only waits when a new total is due while the previous one
// is still untaken. Reset clears the sum, the flag and the output valid; the
// coefficient tables hold no reset value and must be written before use.
// ---------------------------------------------------------------------------
`include "lj_cutoff_pair_energy_core_defines.svh"

module lj_cutoff_pair_energy_core #(
    parameter int NTYPES = ljc_pkg::NTYPES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: center_type[2:0], neighbor_type[5:3], center_x[37:6],
    // center_y[69:38], center_z[101:70], neighbor_x[133:102],
    // neighbor_y[165:134], neighbor_z[197:166], coef_value[261:198]
    input  logic [ljc_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[0], coef_select[2:1]
    input  logic [ljc_pkg::S_USER_W-1:0]  s_axis_tuser,
    input  logic                          s_axis_tlast,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: energy[63:0]
    output logic [ljc_pkg::Q_W-1:0]       m_axis_tdata,
    // tuser: saturated[0]
    output logic                          m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);

    import ljc_pkg::*;

    localparam int TAB_DEPTH = NTYPES * NTYPES;
    localparam int IDX_W     = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
    localparam int RAM_DEPTH = 4 * (1 << IDX_W);
    localparam int RAM_AW    = IDX_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_SQ, ST_CHK, ST_DIV, ST_QSET, ST_MUL,
        ST_QFIN, ST_SUBB, ST_SUBS, ST_ACC, ST_FIN
    } t_state;

    t_state r_state;

    // input field views
    logic [TYPE_W-1:0] in_ct, in_nt;
    logic              in_req;
    logic [1:0]        in_sel;
    logic [63:0]       in_coef;
    logic              in_ok;
    logic [IDX_W-1:0]  in_idx;
    logic              s_xfer;

    assign in_ct   = s_axis_tdata[2:0];
    assign in_nt   = s_axis_tdata[5:3];
    assign in_coef = s_axis_tdata[261:198];
    assign in_req  = s_axis_tuser[0];
    assign in_sel  = s_axis_tuser[2:1];
    assign in_ok   = ({4'd0, in_ct} < 7'(NTYPES)) && ({4'd0, in_nt} < 7'(NTYPES));
    assign in_idx  = IDX_W'(int'(in_ct) * NTYPES + int'(in_nt));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // registered request
    logic [CRD_W-1:0] r_cx, r_cy, r_cz, r_nx, r_ny, r_nz;
    logic             r_last;
    logic [IDX_W-1:0] r_idx;

    // working registers
    logic [6:0]   r_cnt;
    logic [63:0]  r_cut, r_ca, r_cb, r_csh;
    logic [63:0]  r_rsq, r_r2, r_r6, r_tmp, r_q;
    logic [64:0]  r_rem;
    logic [63:0]  r_ma, r_mb;
    logic         r_mneg;
    logic [1:0]   r_qop;
    logic [127:0] r_prod;
    logic [63:0]  r_pp;
    logic [63:0]  r_sum;
    logic         r_sat;
    logic [63:0]  r_odata;
    logic         r_osat, r_ovld;

    // coefficient RAM: address is {table, type pair}
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]       ram_rdata;

    assign ram_we    = s_xfer && (in_req == REQ_COEF) && in_ok;
    assign ram_waddr = {in_sel, in_idx};
    assign ram_raddr = {r_cnt[1:0], r_idx};

    ljc_ram #(
        .WIDTH (Q_W),
        .DEPTH (RAM_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_coef),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // coordinate difference magnitude for the current axis
    logic [CRD_W-1:0] sq_c, sq_n;
    logic [32:0]      sq_d, sq_abs;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin sq_c = r_cx; sq_n = r_nx; end
            2'd1:    begin sq_c = r_cy; sq_n = r_ny; end
            default: begin sq_c = r_cz; sq_n = r_nz; end
        endcase
        sq_d   = {sq_c[31], sq_c} - {sq_n[31], sq_n};
        sq_abs = sq_d[32] ? (33'd0 - sq_d) : sq_d;
    end

    // shared 32x32 multiplier operands
    logic [31:0] mul_x, mul_y;

    always_comb begin
        if (r_state == ST_SQ) begin
            mul_x = sq_abs[31:0];
            mul_y = sq_abs[31:0];
        end else begin
            mul_x = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
            mul_y = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        end
    end

    // operands of the next product stage
    logic [63:0] op_a, op_b;

    always_comb begin
        case (r_qop)
            OP_R4:   begin op_a = r_r2;  op_b = r_r2;  end
            OP_R6:   begin op_a = r_tmp; op_b = r_r2;  end
            OP_AR6:  begin op_a = r_ca;  op_b = r_r6;  end
            default: begin op_a = r_r6;  op_b = r_tmp; end
        endcase
    end

    // partial product placement within the 128-bit magnitude product
    logic [1:0]   pp_j;
    logic [127:0] pp_sh;

    always_comb begin
        pp_j = 2'(r_cnt[2:0] - 3'd1);
        case (pp_j)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd3:    pp_sh = {r_pp, 64'd0};
            default: pp_sh = {32'd0, r_pp, 32'd0};
        endcase
    end

    // squared distance accumulation, saturating
    logic [64:0] rsq_sum;
    assign rsq_sum = {1'b0, r_rsq} + {1'b0, r_pp};

    // reciprocal step: one quotient bit of 2^64 / rsq
    logic [64:0] div_tr;
    logic        div_ge;
    assign div_tr = {r_rem[63:0], (r_cnt == 7'd0)};
    assign div_ge = (div_tr >= {1'b0, r_rsq});

    t_sat_res q_res, sub_res, acc_res;
    assign q_res   = q_final(r_prod, r_mneg);
    assign sub_res = sat_sub(r_tmp, (r_state == ST_SUBB) ? r_cb : r_csh);
    assign acc_res = sat_add(r_sum, r_tmp);

    // multiplier output register
    always_ff @(posedge i_clk) begin
        r_pp <= mul_x * mul_y;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sat   <= 1'b0;
            r_ovld  <= 1'b0;
            r_qop   <= OP_R4;
        end else begin
            // output taken, unless a new total is loaded in this cycle
            if (r_ovld && m_axis_tready && !(r_state == ST_FIN && r_last)) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_xfer && (in_req == REQ_PAIR)) begin
                        r_cx    <= s_axis_tdata[37:6];
                        r_cy    <= s_axis_tdata[69:38];
                        r_cz    <= s_axis_tdata[101:70];
                        r_nx    <= s_axis_tdata[133:102];
                        r_ny    <= s_axis_tdata[165:134];
                        r_nz    <= s_axis_tdata[197:166];
                        r_last  <= s_axis_tlast;
                        r_idx   <= in_idx;
                        r_cnt   <= '0;
                        r_state <= in_ok ? ST_RD : ST_FIN;
                    end
                end
                // four table reads, one per cycle
                ST_RD: begin
                    case (r_cnt[2:0])
                        3'd1:    r_cut <= ram_rdata;
                        3'd2:    r_ca  <= ram_rdata;
                        3'd3:    r_cb  <= ram_rdata;
                        3'd4:    r_csh <= ram_rdata;
                        default: ;
                    endcase
                    if (r_cnt == 7'd4) begin
                        r_cnt   <= '0;
                        r_rsq   <= '0;
                        r_state <= ST_SQ;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                // three squares through the multiplier
                ST_SQ: begin
                    if (r_cnt != 7'd0) begin
                        r_rsq <= rsq_sum[64] ? {64{1'b1}} : rsq_sum[63:0];
                    end
                    if (r_cnt == 7'd3) begin
                        r_state <= ST_CHK;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                // cut-off test and tiny-distance cases
                ST_CHK: begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_qop <= OP_R4;
                    if (!r_cut[63] && (r_cut != 64'd0) && (r_rsq < r_cut)) begin
                        if (r_rsq == 64'd0) begin
                            r_sat   <= 1'b1;
                            r_state <= ST_FIN;
                        end else if (r_rsq <= 64'd2) begin
                            r_sat   <= 1'b1;
                            r_r2    <= SMAX;
                            r_state <= ST_QSET;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                // restoring division, one bit per cycle
                ST_DIV: begin
                    r_rem <= div_ge ? (div_tr - {1'b0, r_rsq}) : div_tr;
                    r_q   <= {r_q[62:0], div_ge};
                    if (r_cnt == 7'd64) begin
                        r_r2    <= {r_q[62:0], div_ge};
                        r_state <= ST_QSET;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                // load magnitudes of the next product
                ST_QSET: begin
                    r_ma    <= op_a[63] ? (64'd0 - op_a) : op_a;
                    r_mb    <= op_b[63] ? (64'd0 - op_b) : op_b;
                    r_mneg  <= op_a[63] ^ op_b[63];
                    r_prod  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_MUL;
                end
                // four partial products, each accumulated the cycle after it is formed
                ST_MUL: begin
                    if (r_cnt != 7'd0) begin
                        r_prod <= r_prod + pp_sh;
                    end
                    if (r_cnt == 7'd4) begin
                        r_state <= ST_QFIN;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_QFIN: begin
                    if (q_res.ovf) begin
                        r_sat <= 1'b1;
                    end
                    case (r_qop)
                        OP_R4: begin
                            r_tmp   <= q_res.val;
                            r_qop   <= OP_R6;
                            r_state <= ST_QSET;
                        end
                        OP_R6: begin
                            r_r6    <= q_res.val;
                            r_qop   <= OP_AR6;
                            r_state <= ST_QSET;
                        end
                        OP_AR6: begin
                            r_tmp   <= q_res.val;
                            r_state <= ST_SUBB;
                        end
                        default: begin
                            r_tmp   <= q_res.val;
                            r_state <= ST_SUBS;
                        end
                    endcase
                end
                // t = A*r6inv - B
                ST_SUBB: begin
                    r_tmp   <= sub_res.val;
                    r_sat   <= r_sat | sub_res.ovf;
                    r_qop   <= OP_PHI;
                    r_state <= ST_QSET;
                end
                // phi = r6inv*t - shift
                ST_SUBS: begin
                    r_tmp   <= sub_res.val;
                    r_sat   <= r_sat | sub_res.ovf;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_sum   <= acc_res.val;
                    r_sat   <= r_sat | acc_res.ovf;
                    r_state <= ST_FIN;
                end
                // emit the total on the last neighbour
                ST_FIN: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (!r_ovld || m_axis_tready) begin
                        r_odata <= r_sum;
                        r_osat  <= r_sat;
                        r_ovld  <= 1'b1;
                        r_sum   <= '0;
                        r_sat   <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;
    assign m_axis_tvalid = r_ovld;

    // the divider only runs on distances above two LSBs
    `LJC_ASSERT(a_div_rsq, i_clk, i_rst_n, (r_state == ST_DIV) |-> (r_rsq > 64'd2))
    // a new total is only issued from the final step of a last neighbour
    `LJC_ASSERT(a_out_src, i_clk, i_rst_n, (!r_ovld ##1 r_ovld) |-> $past(r_state == ST_FIN && r_last))
    // issuing a total clears the running sum and flag
    `LJC_ASSERT(a_out_clr, i_clk, i_rst_n, (!r_ovld ##1 r_ovld) |-> (r_sum == 64'd0 && !r_sat))
    // the table RAM is never written while a pair is in flight
    `LJC_ASSERT(a_no_wr_busy, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !ram_we)

endmodule

[hw/rtl/ljc_ram.sv]
// ---------------------------------------------------------------------------
// ljc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module ljc_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
